[sv/vseg_pkg.sv]
// Shared types and constants for the volatility shock exposure gate.
// Holds the config struct, the queue entry, the divider request and the status codes.
// No dependencies.
package vseg_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int RING_AW    = $clog2(WINDOW_MAX);
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
  localparam int VAR_W      = 48;
  localparam int Q_DEPTH    = 4;
  localparam int QP_W       = $clog2(Q_DEPTH);
  localparam int QC_W       = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [VAR_W-1:0] VARMAX   = {VAR_W{1'b1}};
  localparam logic [16:0]      ONE_Q16  = 17'd65536;
  localparam logic [VAR_W-1:0] SV_TINY  = 48'd72057;
  localparam logic [19:0]      RECIP3   = 20'd349526;
  localparam logic [19:0]      RECIP5   = 20'd209716;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_DECAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOCK_DECAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LOWER         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_UPPER         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_FLOOR  = 3'd6;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_PRIMED  = 2'd1;
  localparam logic [1:0] ST_EARLY   = 2'd2;
  localparam logic [1:0] ST_SAMPLED = 2'd3;

  typedef struct packed {
    logic [39:0] sample_interval_ns;
    logic [6:0]  window_length;
    logic [15:0] vol_decay;
    logic [15:0] shock_decay;
    logic [23:0] z_lower;
    logic [23:0] z_upper;
    logic [16:0] exposure_floor;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [32:0] mid_sum;
    logic [32:0] prev_mid_sum;
  } q_entry_t;

  typedef struct packed {
    logic [VAR_W-1:0] den;
    logic [VAR_W-1:0] rem0;
    logic [VAR_W-1:0] num;
    logic [5:0]       steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAR_W-1:0] quo;
  } div_rsp_t;

endpackage

[sv/vseg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vseg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vseg_front.sv]
// Front end: accepts quotes, classifies them and queues them for the back end.
// Owns the last mid and last sample time. Uses vseg_pkg.
module vseg_front (
  input  logic               clk,
  input  logic               rst,
  input  vseg_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        bid_price,
  input  logic [31:0]        ask_price,
  input  logic [63:0]        quote_time_ns,
  output logic               q_valid,
  output vseg_pkg::q_entry_t q_head,
  input  logic               q_pop
);
  import vseg_pkg::*;

  q_entry_t         q_mem [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr, rd_ptr;
  logic [QC_W-1:0]  count;
  logic [32:0]      last_mid;
  logic [63:0]      last_ns;
  logic [32:0]      mid;
  logic [63:0]      elapsed;
  logic [1:0]       cls;
  logic             push;

  assign in_stall = (count == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = q_mem[rd_ptr];
  assign mid      = {1'b0, bid_price} + {1'b0, ask_price};
  assign elapsed  = quote_time_ns - last_ns;

  always_comb begin
    if (bid_price == '0 || ask_price == '0) begin
      cls = ST_INVALID;
    end else if (last_mid == '0) begin
      cls = ST_PRIMED;
    end else if (last_ns != '0 && elapsed < 64'(cfg.sample_interval_ns)) begin
      cls = ST_EARLY;
    end else begin
      cls = ST_SAMPLED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      last_mid <= '0;
      last_ns  <= '0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= '{status: cls, mid_sum: mid, prev_mid_sum: last_mid};
        wr_ptr        <= wr_ptr + 1'b1;
        if (cls == ST_PRIMED || cls == ST_SAMPLED) begin
          last_mid <= mid;
          last_ns  <= quote_time_ns;
        end
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QC_W'(push) - QC_W'(q_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(Q_DEPTH)) else $error("queue count overflow");

  a_mid_tracks: assert property (@(posedge clk) disable iff (rst)
    push && cls == ST_SAMPLED |=> last_mid == $past(mid))
    else $error("last mid not updated on sample");

endmodule

[sv/vseg_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Remainder starts at rem0 (below den); num bits shift in from the top. Uses vseg_pkg.
module vseg_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vseg_pkg::div_req_t req,
  output vseg_pkg::div_rsp_t rsp
);
  import vseg_pkg::*;

  logic [VAR_W-1:0] den, rem, nsh, quo;
  logic [5:0]       cnt;
  logic             busy, done;
  logic [VAR_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem, nsh[VAR_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign rsp   = '{done: done, quo: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den  <= req.den;
        rem  <= req.rem0;
        nsh  <= req.num;
        cnt  <= req.steps;
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[VAR_W-1:0] : trial[VAR_W-1:0];
        quo <= {quo[VAR_W-2:0], ge};
        nsh <= {nsh[VAR_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/vseg_back.sv]
// Back end: sequencer for the squared return, window sum, EWMAs, z-score and gate.
// Shares one 32x32 multiplier and vseg_div; the ring is a vseg_ram. Uses vseg_pkg.
module vseg_back (
  input  logic               clk,
  input  logic               rst,
  input  vseg_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  vseg_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [47:0]        vol_level,
  output logic [23:0]        shock_z,
  output logic [16:0]        exposure
);
  import vseg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_DIV1, S_WDIV1, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_RING, S_DROP, S_ADD, S_VOL, S_B1, S_B2, S_B3, S_B4, S_B5,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_SV, S_Z, S_DIV2, S_WDIV2, S_SQ,
    S_GATE, S_PMUL, S_DIV3, S_WDIV3, S_DONE
  } state_t;

  state_t           state;
  logic [32:0]      a_mid, b_mid;
  logic [25:0]      u;
  logic [21:0]      u2;
  logic [17:0]      u3, q3;
  logic [9:0]       u5;
  logic [27:0]      r;
  logic [VAR_W-1:0] sq, window_sum, vol, prev_vol, sv, d, sqrad;
  logic [RING_AW-1:0] ring_head;
  logic [FILL_W-1:0]  ring_fill;
  logic [23:0]      z_held;
  logic [16:0]      exp_held;
  logic             bsel;
  logic [49:0]      bacc;
  logic [33:0]      blo;
  logic [95:0]      dsq;
  logic [25:0]      srem;
  logic [23:0]      root;
  logic [4:0]       sqcnt;
  logic [63:0]      prod;
  logic [31:0]      ma, mb;

  logic             out_free;
  logic [FILL_W-1:0] wl;
  logic [VAR_W-1:0] bold, bfresh, bres, ssq, ram_rdata;
  logic [15:0]      bw;
  logic [16:0]      bv, fl;
  logic [VAR_W:0]   ws_add;
  logic [27:0]      remx, tsq;
  logic [7:0]       q5;
  logic [26:0]      rsum;
  logic             div_start;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             ram_we;
  logic [RING_AW-1:0] ram_raddr;

  assign out_free = !out_valid || !out_stall;
  assign wl = (cfg.window_length == '0) ? FILL_W'(1) :
              (cfg.window_length > 7'(WINDOW_MAX)) ? FILL_W'(WINDOW_MAX) :
              FILL_W'(cfg.window_length);
  assign bold   = bsel ? sv : prev_vol;
  assign bfresh = bsel ? ssq : window_sum;
  assign bw     = bsel ? cfg.shock_decay : cfg.vol_decay;
  assign bv     = ONE_Q16 - 17'(bw);
  assign bres   = VAR_W'(bacc + 50'((blo + 34'(prod)) >> 16));
  assign ssq    = VAR_W'(dsq[95:56]);
  assign ws_add = {1'b0, window_sum} + {1'b0, sq};
  assign fl     = (cfg.exposure_floor > ONE_Q16) ? ONE_Q16 : cfg.exposure_floor;
  assign remx   = {srem, sqrad[VAR_W-1 -: 2]};
  assign tsq    = {2'b00, root, 2'b01};
  assign q5     = prod[27:20];
  assign rsum   = 27'(u) + 27'(q3) + 27'(q5);
  assign ram_we = (state == S_ADD);
  assign ram_raddr = ring_head - ring_fill[RING_AW-1:0];

  vseg_ram #(.WIDTH(VAR_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_head),
    .wdata (sq),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vseg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    unique case (state)
      S_DIV1: begin
        div_start     = 1'b1;
        div_req.den   = VAR_W'({1'b0, a_mid} + {1'b0, b_mid});
        div_req.rem0  = VAR_W'((a_mid > b_mid) ? a_mid - b_mid : b_mid - a_mid);
        div_req.steps = 6'd30;
      end
      S_DIV2: begin
        div_start     = 1'b1;
        div_req.den   = sv;
        div_req.rem0  = VAR_W'(dsq[95:72]);
        div_req.num   = dsq[71:24];
        div_req.steps = 6'd48;
      end
      S_DIV3: begin
        div_start     = 1'b1;
        div_req.den   = VAR_W'(cfg.z_upper - cfg.z_lower);
        div_req.rem0  = VAR_W'(prod[39:17]);
        div_req.num   = {prod[16:0], 31'b0};
        div_req.steps = 6'd17;
      end
      default: ;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_M1: begin ma = 32'(u);            mb = 32'(u);  end
      S_M2: begin ma = 32'(prod[51:30]);  mb = 32'(u);  end
      S_M3: begin ma = 32'(prod[47:30]);  mb = 32'(u2); end
      S_M4: begin ma = 32'(u3);           mb = 32'(RECIP3); end
      S_M5: begin ma = 32'(u5);           mb = 32'(RECIP5); end
      S_M7: begin ma = 32'(r);            mb = 32'(r);  end
      S_B1: begin ma = bold[47:16];       mb = 32'(bw); end
      S_B2: begin ma = bfresh[47:16];     mb = 32'(bv); end
      S_B3: begin ma = 32'(bold[15:0]);   mb = 32'(bw); end
      S_B4: begin ma = 32'(bfresh[15:0]); mb = 32'(bv); end
      S_D1: begin ma = d[31:0];           mb = d[31:0]; end
      S_D2: begin ma = 32'(d[47:32]);     mb = d[31:0]; end
      S_D3: begin ma = 32'(d[47:32]);     mb = 32'(d[47:32]); end
      S_PMUL: begin ma = 32'(z_held - cfg.z_lower); mb = 32'(ONE_Q16 - fl); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= 64'(ma) * 64'(mb);
    q_pop <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      q_pop      <= 1'b0;
      ring_head  <= '0;
      ring_fill  <= '0;
      window_sum <= '0;
      vol        <= '0;
      sv         <= '0;
      z_held     <= '0;
      exp_held   <= ONE_Q16;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && out_free && !q_pop) begin
            q_pop <= 1'b1;
            a_mid <= q_head.mid_sum;
            b_mid <= q_head.prev_mid_sum;
            if (q_head.status == ST_SAMPLED) begin
              state <= S_DIV1;
            end else begin
              out_valid <= 1'b1;
              status    <= q_head.status;
              vol_level <= vol;
              shock_z   <= z_held;
              exposure  <= exp_held;
            end
          end
        end
        S_DIV1: state <= S_WDIV1;
        S_WDIV1: begin
          if (div_rsp.done) begin
            if (div_rsp.quo[VAR_W-1:26] != '0) begin
              sq    <= VARMAX;
              state <= S_RING;
            end else begin
              u     <= div_rsp.quo[25:0];
              state <= S_M1;
            end
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin u2 <= prod[51:30]; state <= S_M3; end
        S_M3: begin u3 <= prod[47:30]; state <= S_M4; end
        S_M4: begin u5 <= prod[39:30]; state <= S_M5; end
        S_M5: begin q3 <= prod[37:20]; state <= S_M6; end
        S_M6: begin r <= {rsum, 1'b0}; state <= S_M7; end
        S_M7: state <= S_M8;
        S_M8: begin
          sq    <= (prod[55:52] != '0) ? VARMAX : prod[51:4];
          state <= S_RING;
        end
        S_RING: state <= (ring_fill >= wl) ? S_DROP : S_ADD;
        S_DROP: begin
          window_sum <= (window_sum > ram_rdata) ? window_sum - ram_rdata : '0;
          ring_fill  <= ring_fill - 1'b1;
          state      <= S_ADD;
        end
        S_ADD: begin
          ring_head  <= ring_head + 1'b1;
          ring_fill  <= ring_fill + 1'b1;
          window_sum <= ws_add[VAR_W] ? VARMAX : ws_add[VAR_W-1:0];
          state      <= S_VOL;
        end
        S_VOL: begin
          prev_vol <= vol;
          if (vol == '0) begin
            vol   <= window_sum;
            state <= S_D0;
          end else begin
            bsel  <= 1'b0;
            state <= S_B1;
          end
        end
        S_B1: state <= S_B2;
        S_B2: begin bacc <= 50'(prod); state <= S_B3; end
        S_B3: begin bacc <= bacc + 50'(prod); state <= S_B4; end
        S_B4: begin blo <= 34'(prod); state <= S_B5; end
        S_B5: begin
          if (bsel) begin
            sv    <= bres;
            state <= S_Z;
          end else begin
            vol   <= bres;
            state <= S_D0;
          end
        end
        S_D0: begin
          d     <= (vol >= prev_vol) ? vol - prev_vol : prev_vol - vol;
          state <= S_D1;
        end
        S_D1: state <= S_D2;
        S_D2: begin dsq <= 96'(prod); state <= S_D3; end
        S_D3: begin dsq <= dsq + (96'(prod) << 33); state <= S_D4; end
        S_D4: begin dsq <= dsq + (96'(prod) << 64); state <= S_SV; end
        S_SV: begin
          if (sv == '0) begin
            sv    <= ssq;
            state <= S_Z;
          end else begin
            bsel  <= 1'b1;
            state <= S_B1;
          end
        end
        S_Z: begin
          if (sv <= SV_TINY) begin
            z_held <= '0;
            state  <= S_GATE;
          end else if (VAR_W'(dsq[95:72]) >= sv) begin
            z_held <= '1;
            state  <= S_GATE;
          end else begin
            state <= S_DIV2;
          end
        end
        S_DIV2: state <= S_WDIV2;
        S_WDIV2: begin
          if (div_rsp.done) begin
            sqrad <= div_rsp.quo;
            srem  <= '0;
            root  <= '0;
            sqcnt <= 5'd24;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sqrad <= sqrad << 2;
          sqcnt <= sqcnt - 1'b1;
          if (remx >= tsq) begin
            srem <= 26'(remx - tsq);
            root <= {root[22:0], 1'b1};
          end else begin
            srem <= 26'(remx);
            root <= {root[22:0], 1'b0};
          end
          if (sqcnt == 5'd1) begin
            z_held <= {root[22:0], remx >= tsq};
            state  <= S_GATE;
          end
        end
        S_GATE: begin
          if (z_held <= cfg.z_lower) begin
            exp_held <= ONE_Q16;
            state    <= S_DONE;
          end else if (z_held >= cfg.z_upper) begin
            exp_held <= fl;
            state    <= S_DONE;
          end else begin
            state <= S_PMUL;
          end
        end
        S_PMUL: state <= S_DIV3;
        S_DIV3: state <= S_WDIV3;
        S_WDIV3: begin
          if (div_rsp.done) begin
            exp_held <= ONE_Q16 - div_rsp.quo[16:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= ST_SAMPLED;
            vol_level <= vol;
            shock_z   <= z_held;
            exposure  <= exp_held;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(WINDOW_MAX)) else $error("ring fill above window");

  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    exp_held <= ONE_Q16) else $error("exposure above one");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> $past(q_valid)) else $error("pop of empty queue");

endmodule

[sv/volatility_shock_exposure_gate.sv]
// Top level: config registers, quote front end, queue and arithmetic back end.
// Invalid, priming or early quotes go from the queue head to the output registers.
// A sample is bound by the shared bit-serial divider (95 steps over three divides)
// and the 24-step square root; quotes go one at a time, four can wait in the queue.
// Reset (rst, synchronous): config to defaults, state cleared, ring left unwritten.
module volatility_shock_exposure_gate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [vseg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vseg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        bid_price,
  input  logic [31:0]                        ask_price,
  input  logic [63:0]                        quote_time_ns,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [47:0]                        vol_level,
  output logic [23:0]                        shock_z,
  output logic [16:0]                        exposure
);
  import vseg_pkg::*;

  cfg_t     cfg;
  logic     q_valid, q_pop;
  q_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ns <= 40'd1000000000;
      cfg.window_length      <= 7'd60;
      cfg.vol_decay          <= 16'd61604;
      cfg.shock_decay        <= 16'd61604;
      cfg.z_lower            <= 24'd65536;
      cfg.z_upper            <= 24'd196608;
      cfg.exposure_floor     <= 17'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLE_INTERVAL: cfg.sample_interval_ns <= cfg_data;
        CFG_WINDOW_LENGTH:   cfg.window_length      <= cfg_data[6:0];
        CFG_VOL_DECAY:       cfg.vol_decay          <= cfg_data[15:0];
        CFG_SHOCK_DECAY:     cfg.shock_decay        <= cfg_data[15:0];
        CFG_Z_LOWER:         cfg.z_lower            <= cfg_data[23:0];
        CFG_Z_UPPER:         cfg.z_upper            <= cfg_data[23:0];
        CFG_EXPOSURE_FLOOR:  cfg.exposure_floor     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  vseg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .bid_price     (bid_price),
    .ask_price     (ask_price),
    .quote_time_ns (quote_time_ns),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  vseg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .vol_level (vol_level),
    .shock_z   (shock_z),
    .exposure  (exposure)
  );

endmodule

[tb/sv/tb_volatility_shock_exposure_gate.sv]
// Testbench for volatility_shock_exposure_gate: quotes are driven with random gaps and
// checked against an in-bench prediction of the volatility, shock z-score and exposure.
// Depends on vseg_pkg and the volatility_shock_exposure_gate RTL.
`timescale 1ns / 1ps

module tb_volatility_shock_exposure_gate;
  import vseg_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] vol;
    logic [23:0] z;
    logic [16:0] expo;
  } quote_result_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int EXP_DEPTH      = 2048;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] bid_price, ask_price;
  logic [63:0] quote_time_ns;
  logic [1:0] status;
  logic [47:0] vol_level;
  logic [23:0] shock_z;
  logic [16:0] exposure;

  volatility_shock_exposure_gate u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .bid_price(bid_price), .ask_price(ask_price), .quote_time_ns(quote_time_ns),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .vol_level(vol_level), .shock_z(shock_z), .exposure(exposure)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // gate state mirror
  cfg_t        gate_cfg;
  logic [47:0] sq_ring [WINDOW_MAX];
  logic [6:0]  ring_head, ring_fill;
  logic [47:0] window_sum, vol_smoothed, shock_var;
  logic [32:0] last_mid;
  logic [63:0] last_sample_ns;
  logic [16:0] exposure_held;
  logic [23:0] z_held;

  quote_result_t exp_fifo [EXP_DEPTH];
  int exp_wr, exp_rd;
  int mismatches;
  int idle_cycles;
  int stall_hold;
  int burst_left;
  bit no_gaps;

  // generator state
  logic [31:0] walk_bid;
  logic [63:0] walk_ns;

  function automatic logic [47:0] log_return_sq(logic [32:0] a, logic [32:0] b);
    logic [63:0] diff, u, u2, u3, u5, r, sq;
    diff = (a > b) ? 64'(a - b) : 64'(b - a);
    u = (diff << 30) / (64'(a) + 64'(b));
    if (u >= 64'd1 << 26) return VARMAX;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u5 = (u3 * u2) >> 30;
    r = 2 * (u + u3 / 3 + u5 / 5);
    sq = (r * r) >> 4;
    return (sq > 64'(VARMAX)) ? VARMAX : sq[47:0];
  endfunction

  function automatic logic [47:0] ewma(logic [47:0] old, logic [47:0] fresh, logic [15:0] w);
    logic [127:0] acc;
    acc = 128'(old) * w + 128'(fresh) * (128'd65536 - w);
    return acc[63:16];
  endfunction

  function automatic logic [23:0] shock_score(logic [47:0] d, logic [47:0] sv);
    logic [127:0] target;
    logic [23:0] z, c;
    if (sv <= SV_TINY) return '0;
    target = (128'(d) * d) >> 24;
    z = '0;
    for (int b = 23; b >= 0; b--) begin
      c = z | (24'd1 << b);
      if (128'(c) * c * sv <= target) z = c;
    end
    return z;
  endfunction

  task automatic take_sample(logic [32:0] mid);
    logic [6:0] wl;
    logic [47:0] sq, prev, d, ssq, old, span_floor;
    logic [127:0] dd;
    wl = gate_cfg.window_length;
    if (wl < 1) wl = 1;
    if (wl > WINDOW_MAX) wl = 7'(WINDOW_MAX);
    sq = log_return_sq(mid, last_mid);
    if (ring_fill + 1 > wl && ring_fill > 0) begin
      old = sq_ring[6'(ring_head - ring_fill)];
      window_sum = (window_sum > old) ? window_sum - old : '0;
      ring_fill--;
    end
    sq_ring[6'(ring_head)] = sq;
    ring_head = 7'((ring_head + 1) % WINDOW_MAX);
    ring_fill++;
    window_sum = (VARMAX - window_sum < sq) ? VARMAX : window_sum + sq;
    prev = vol_smoothed;
    vol_smoothed = (prev == 0) ? window_sum : ewma(prev, window_sum, gate_cfg.vol_decay);
    d = (vol_smoothed >= prev) ? vol_smoothed - prev : prev - vol_smoothed;
    dd = (128'(d) * d) >> 56;
    ssq = (dd > 128'(VARMAX)) ? VARMAX : dd[47:0];
    shock_var = (shock_var == 0) ? ssq : ewma(shock_var, ssq, gate_cfg.shock_decay);
    z_held = shock_score(d, shock_var);
    span_floor = (gate_cfg.exposure_floor > ONE_Q16) ? ONE_Q16 : gate_cfg.exposure_floor;
    if (z_held <= gate_cfg.z_lower)
      exposure_held = ONE_Q16;
    else if (z_held >= gate_cfg.z_upper)
      exposure_held = span_floor[16:0];
    else
      exposure_held = ONE_Q16 - 17'((64'(z_held - gate_cfg.z_lower) * (64'(ONE_Q16) - span_floor))
                      / (gate_cfg.z_upper - gate_cfg.z_lower));
  endtask

  task automatic gate_quote(logic [31:0] bid, logic [31:0] ask, logic [63:0] ts,
                            output quote_result_t res);
    logic [32:0] mid;
    if (bid == 0 || ask == 0) begin
      res.status = ST_INVALID;
    end else begin
      mid = 33'(bid) + ask;
      if (last_mid == 0) begin
        last_mid = mid;
        last_sample_ns = ts;
        res.status = ST_PRIMED;
      end else if (last_sample_ns != 0 && ts - last_sample_ns < 64'(gate_cfg.sample_interval_ns)) begin
        res.status = ST_EARLY;
      end else begin
        take_sample(mid);
        last_mid = mid;
        last_sample_ns = ts;
        res.status = ST_SAMPLED;
      end
    end
    res.vol = vol_smoothed;
    res.z = z_held;
    res.expo = exposure_held;
  endtask

  task automatic wait_drained();
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SAMPLE_INTERVAL: gate_cfg.sample_interval_ns = data[39:0];
      CFG_WINDOW_LENGTH:   gate_cfg.window_length = data[6:0];
      CFG_VOL_DECAY:       gate_cfg.vol_decay = data[15:0];
      CFG_SHOCK_DECAY:     gate_cfg.shock_decay = data[15:0];
      CFG_Z_LOWER:         gate_cfg.z_lower = data[23:0];
      CFG_Z_UPPER:         gate_cfg.z_upper = data[23:0];
      CFG_EXPOSURE_FLOOR:  gate_cfg.exposure_floor = data[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_quote(logic [31:0] bid, logic [31:0] ask, logic [63:0] ts);
    quote_result_t res;
    int gap;
    in_valid <= 1'b1;
    bid_price <= bid;
    ask_price <= ask;
    quote_time_ns <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gate_quote(bid, ask, ts, res);
    exp_fifo[exp_wr % EXP_DEPTH] = res;
    exp_wr++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_gaps) begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_walk_quote(int unsigned step_max, int unsigned gap_max);
    int unsigned pick;
    logic [31:0] spread;
    pick = $urandom_range(0, 99);
    spread = $urandom_range(1, 50);
    walk_ns += $urandom_range(0, gap_max);
    if (pick < 3) begin
      send_quote($urandom, $urandom, {$urandom, $urandom});
    end else if (pick < 6) begin
      send_quote((pick == 3) ? 32'd0 : walk_bid, (pick == 5) ? 32'd0 : walk_bid, walk_ns);
    end else if (pick < 8) begin
      send_quote(walk_bid, walk_bid + spread, walk_ns - $urandom_range(1, 5000));
    end else begin
      if (pick < 10) walk_bid = walk_bid + (walk_bid >> $urandom_range(1, 4));
      else if ($urandom_range(0, 1)) walk_bid += $urandom_range(0, step_max);
      else walk_bid -= $urandom_range(0, step_max);
      if (walk_bid < 32'd1000 || walk_bid > 32'hF000_0000) walk_bid = 32'd1_000_000;
      send_quote(walk_bid, walk_bid + spread, walk_ns);
    end
  endtask

  task automatic test_quote_states();
    send_quote(32'd0, 32'd100, 64'd5);
    send_quote(32'd100, 32'd0, 64'd5);
    send_quote(32'd0, 32'd0, 64'd0);
    send_quote(32'd1000, 32'd1002, 64'd0);
    send_quote(32'd1001, 32'd1003, 64'd10);
    send_quote(32'd1003, 32'd1005, 64'd20);
    send_quote(32'd1004, 32'd1006, 64'd1_000_000_020);
    send_quote(32'd1005, 32'd1007, 64'd1_000_000_021);
    send_quote(32'd1000, 32'd1001, 64'd500);
    send_quote(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_quote(32'd1, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_quote(32'd1, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_quote(32'hFFFF_FFFF, 32'd1, 64'h0);
    end_burst();
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_SAMPLE_INTERVAL, 40'hFF_FFFF_FFFF);
    write_reg(CFG_WINDOW_LENGTH, 7'd0);
    write_reg(CFG_VOL_DECAY, 16'hFFFF);
    write_reg(CFG_SHOCK_DECAY, 16'd0);
    write_reg(CFG_Z_LOWER, 24'hFF_FFFF);
    write_reg(CFG_Z_UPPER, 24'd0);
    write_reg(CFG_EXPOSURE_FLOOR, 17'h1_FFFF);
    send_quote(32'd2000, 32'd2001, 64'd100);
    send_quote(32'd2100, 32'd2101, 64'd200);
    send_quote(32'd2100, 32'd2101, 64'd200 + 64'hFF_FFFF_FFFF);
    end_burst();
    wait_drained();
    write_reg(CFG_SAMPLE_INTERVAL, 40'd0);
    write_reg(CFG_Z_LOWER, 24'd0);
    send_quote(32'd1900, 32'd1901, 64'd300);
    send_quote(32'd2500, 32'd2501, 64'd300);
    send_quote(32'd1500, 32'd1501, 64'd301);
    end_burst();
    wait_drained();
  endtask

  task automatic run_phase(logic [39:0] ival, logic [6:0] wlen, logic [15:0] vd, logic [15:0] sd,
                           logic [23:0] zl, logic [23:0] zu, logic [16:0] fl,
                           int n, int unsigned step_max);
    write_reg(CFG_SAMPLE_INTERVAL, ival);
    write_reg(CFG_WINDOW_LENGTH, wlen);
    write_reg(CFG_VOL_DECAY, vd);
    write_reg(CFG_SHOCK_DECAY, sd);
    write_reg(CFG_Z_LOWER, zl);
    write_reg(CFG_Z_UPPER, zu);
    write_reg(CFG_EXPOSURE_FLOOR, fl);
    repeat (n) send_walk_quote(step_max, 32'(2 * ival + 2));
    end_burst();
    wait_drained();
  endtask

  task automatic test_backpressure();
    stall_hold = 600;
    no_gaps = 1'b1;
    repeat (30) send_walk_quote(2000, 1500);
    no_gaps = 1'b0;
    end_burst();
    wait_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    quote_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d vol=%h z=%h exposure=%h",
                   status, vol_level, shock_z, exposure);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (status !== want.status || vol_level !== want.vol ||
            shock_z !== want.z || exposure !== want.expo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status=%0d vol=%h z=%h exposure=%h, got %0d %h %h %h",
                     want.status, want.vol, want.z, want.expo,
                     status, vol_level, shock_z, exposure);
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  int stall_mode, stall_count;
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_count == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_count <= $urandom_range(16, 128);
      end else begin
        stall_count <= stall_count - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("volatility_shock_exposure_gate test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    bid_price <= '0;
    ask_price <= '0;
    quote_time_ns <= '0;
    out_stall <= 1'b0;
    stall_hold = 0;
    stall_mode = 0;
    stall_count = 0;
    idle_cycles = 0;
    mismatches = 0;
    exp_wr = 0;
    exp_rd = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    gate_cfg = '{sample_interval_ns: 40'd1_000_000_000, window_length: 7'd60,
                 vol_decay: 16'd61604, shock_decay: 16'd61604, z_lower: 24'd65536,
                 z_upper: 24'd196608, exposure_floor: 17'd0};
    foreach (sq_ring[i]) sq_ring[i] = '0;
    ring_head = '0;
    ring_fill = '0;
    window_sum = '0;
    vol_smoothed = '0;
    shock_var = '0;
    last_mid = '0;
    last_sample_ns = '0;
    exposure_held = ONE_Q16;
    z_held = '0;
    walk_bid = 32'd1_000_000;
    walk_ns = 64'd1_000_000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quote_states();
    test_register_extremes();
    run_phase(40'd1000, 7'd60, 16'd61604, 16'd61604, 24'd65536, 24'd196608, 17'd0, 220, 500);
    run_phase(40'd1000, 7'd3, 16'd32768, 16'd60000, 24'd20000, 24'd80000, 17'd16384, 200, 2000);
    run_phase(40'd10, 7'd64, 16'd0, 16'hFFFF, 24'd0, 24'd40000, 17'd65536, 200, 3000);
    test_backpressure();
    run_phase(40'd500, 7'd127, 16'hFFFF, 16'd0, 24'd30000, 24'd30000, 17'd1000, 200, 1000);
    run_phase(40'd0, 7'd1, 16'd50000, 16'd50000, 24'd5000, 24'd300000, 17'd40000, 200, 5000);
    run_phase(40'd2000, 7'd64, 16'd61604, 16'd61604, 24'd65536, 24'd196608, 17'd0, 150, 800);

    repeat (200) @(posedge clk);
    if (mismatches == 0 && exp_wr == exp_rd)
      $display("volatility_shock_exposure_gate test passed");
    else
      $display("volatility_shock_exposure_gate test failed");
    $finish;
  end

endmodule
